@@ hdl/pli_pkg.sv @@
package pli_pkg;

   localparam int CAPACITY    = 64;
   localparam int ENTRY_WIDTH = 32;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam int ACTION_W = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_FRONT = 3'd0,
      ACT_INSERT_BACK  = 3'd1,
      ACT_INSERT_AT    = 3'd2,
      ACT_REMOVE_FRONT = 3'd3,
      ACT_REMOVE_BACK  = 3'd4,
      ACT_REMOVE_AT    = 3'd5,
      ACT_CLEAR        = 3'd6,
      ACT_DUMP         = 3'd7
   } action_type;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERT_REJ = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REMOVE_REJ = 2'd2;

   typedef struct packed {
      action_type          action;
      logic [POS_W-1:0]    position;
      logic [DATA_W-1:0]   entry_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   entry_out;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic                last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_ROTATE = 2'd3
   } cmd_kind_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cmd_kind_type            kind;
      logic [IDX_W-1:0]        idx;
      logic [IDX_W-1:0]        last;
      logic [ENTRY_WIDTH-1:0]  data;
   } chain_cmd_type;

endpackage

@@ hdl/pli_cell.sv @@
module pli_cell (
   input  logic                            clock,
   input  logic [pli_pkg::IDX_W-1:0]       cell_idx,
   input  pli_pkg::chain_cmd_type          cmd,
   input  logic [pli_pkg::ENTRY_WIDTH-1:0] left_value,
   input  logic [pli_pkg::ENTRY_WIDTH-1:0] right_value,
   input  logic [pli_pkg::ENTRY_WIDTH-1:0] head_value,
   output logic [pli_pkg::ENTRY_WIDTH-1:0] value
);

   logic [pli_pkg::ENTRY_WIDTH-1:0] value_ff;
   logic [pli_pkg::ENTRY_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.kind)
         pli_pkg::CMD_INSERT: begin
            if (cell_idx == cmd.idx) begin
               value_in = cmd.data;
            end else if (cell_idx > cmd.idx) begin
               value_in = left_value;
            end
         end
         pli_pkg::CMD_REMOVE: begin
            if (cell_idx >= cmd.idx) begin
               value_in = right_value;
            end
         end
         pli_pkg::CMD_ROTATE: begin
            // head wraps around to the last occupied cell
            if (cell_idx < cmd.last) begin
               value_in = right_value;
            end else if (cell_idx == cmd.last) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ hdl/pli_chain.sv @@
module pli_chain (
   input  logic                            clock,
   input  pli_pkg::chain_cmd_type          cmd,
   input  logic [pli_pkg::IDX_W-1:0]       read_idx,
   output logic [pli_pkg::ENTRY_WIDTH-1:0] read_value,
   output logic [pli_pkg::ENTRY_WIDTH-1:0] head_value
);

   logic [pli_pkg::ENTRY_WIDTH-1:0] cell_value [pli_pkg::CAPACITY];

   for (genvar k = 0; k < pli_pkg::CAPACITY; k++) begin : g_cell
      logic [pli_pkg::ENTRY_WIDTH-1:0] left_value;
      logic [pli_pkg::ENTRY_WIDTH-1:0] right_value;

      if (k == 0) begin : g_first
         assign left_value = cell_value[k];
      end else begin : g_mid_l
         assign left_value = cell_value[k-1];
      end

      if (k == pli_pkg::CAPACITY - 1) begin : g_last
         assign right_value = cell_value[k];
      end else begin : g_mid_r
         assign right_value = cell_value[k+1];
      end

      pli_cell u_cell (
         .clock       (clock),
         .cell_idx    (pli_pkg::IDX_W'(k)),
         .cmd         (cmd),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (cell_value[0]),
         .value       (cell_value[k])
      );
   end

   // and-or selection of the addressed cell
   always_comb begin
      read_value = '0;
      for (int k = 0; k < pli_pkg::CAPACITY; k++) begin
         if (read_idx == pli_pkg::IDX_W'(k)) begin
            read_value = read_value | cell_value[k];
         end
      end
   end

   assign head_value = cell_value[0];

endmodule

@@ hdl/positional_list_insert_remove.sv @@
// channel  | direction | handshake             | payload
// req_     | in        | req_valid / req_ready | pli_pkg::req_type (action, position, entry_in)
// rsp_     | out       | rsp_valid / rsp_ready | pli_pkg::rsp_type (entry_out, status, ...)
//
// insert and remove shift the cells of the chain in place, all at once; clear only resets the entry count
// dump of n entries holds off new requests until all n results have been issued;
// the chain rotates one place per result and is back in order after the last one
// synchronous reset empties the list; cell contents are not cleared
// a stalled result holds in the output register; requests wait while it is full and not taken
module positional_list_insert_remove (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pli_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pli_pkg::rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type                       state_ff, state_in;
   logic [pli_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [pli_pkg::CNT_W-1:0]       remain_ff, remain_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pli_pkg::rsp_type                rsp_ff, rsp_in;

   pli_pkg::chain_cmd_type          cmd;
   logic [pli_pkg::IDX_W-1:0]       read_idx;
   logic [pli_pkg::ENTRY_WIDTH-1:0] read_value;
   logic [pli_pkg::ENTRY_WIDTH-1:0] head_value;

   logic                            out_free;
   logic                            req_fire;
   logic [pli_pkg::POS_W-1:0]       count_ext;
   logic [pli_pkg::POS_W-1:0]       idx_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign count_ext = pli_pkg::POS_W'(count_ff);

   always_comb begin
      case (req_payload.action)
         pli_pkg::ACT_INSERT_BACK: idx_ext = count_ext;
         pli_pkg::ACT_REMOVE_BACK: idx_ext = count_ext - pli_pkg::POS_W'(1);
         pli_pkg::ACT_INSERT_AT,
         pli_pkg::ACT_REMOVE_AT:   idx_ext = req_payload.position;
         default:                  idx_ext = '0;
      endcase
   end

   assign read_idx = pli_pkg::IDX_W'(idx_ext);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd.kind     = pli_pkg::CMD_HOLD;
      cmd.idx      = read_idx;
      cmd.last     = pli_pkg::IDX_W'(count_ff - pli_pkg::CNT_W'(1));
      cmd.data     = pli_pkg::ENTRY_WIDTH'(req_payload.entry_in);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in          = 1'b1;
               rsp_in.entry_out      = '0;
               rsp_in.status         = pli_pkg::STATUS_OK;
               rsp_in.last_of_run    = 1'b1;
               case (req_payload.action)
                  pli_pkg::ACT_INSERT_FRONT,
                  pli_pkg::ACT_INSERT_BACK,
                  pli_pkg::ACT_INSERT_AT: begin
                     if (count_ff >= pli_pkg::CNT_W'(pli_pkg::CAPACITY) ||
                         idx_ext > count_ext) begin
                        rsp_in.status = pli_pkg::STATUS_INSERT_REJ;
                     end else begin
                        cmd.kind = pli_pkg::CMD_INSERT;
                        count_in = count_ff + pli_pkg::CNT_W'(1);
                     end
                  end
                  pli_pkg::ACT_REMOVE_FRONT,
                  pli_pkg::ACT_REMOVE_BACK,
                  pli_pkg::ACT_REMOVE_AT: begin
                     if (count_ff == '0 || idx_ext >= count_ext) begin
                        rsp_in.status = pli_pkg::STATUS_REMOVE_REJ;
                     end else begin
                        cmd.kind         = pli_pkg::CMD_REMOVE;
                        count_in         = count_ff - pli_pkg::CNT_W'(1);
                        rsp_in.entry_out = pli_pkg::DATA_W'(read_value);
                     end
                  end
                  pli_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // dump: an empty list answers at once
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        rsp_in       = rsp_ff;
                        remain_in    = count_ff;
                        state_in     = ST_DUMP;
                     end
                  end
               endcase
               if (rsp_valid_in) begin
                  rsp_in.entry_count = pli_pkg::COUNT_W'(count_in);
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.entry_out   = pli_pkg::DATA_W'(head_value);
               rsp_in.status      = pli_pkg::STATUS_OK;
               rsp_in.entry_count = pli_pkg::COUNT_W'(count_ff);
               rsp_in.last_of_run = (remain_ff == pli_pkg::CNT_W'(1));
               cmd.kind           = pli_pkg::CMD_ROTATE;
               remain_in          = remain_ff - pli_pkg::CNT_W'(1);
               if (remain_ff == pli_pkg::CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   pli_chain u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .read_idx   (read_idx),
      .read_value (read_value),
      .head_value (head_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ hdl/pli_checker.sv @@
module pli_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pli_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pli_pkg::rsp_type rsp_payload
);

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transaction changed while stalled");

   // a rejected request carries no entry
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != pli_pkg::STATUS_OK |->
         rsp_payload.entry_out == '0 && rsp_payload.last_of_run)
      else $error("rejected transaction with entry or open run");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.entry_count <= pli_pkg::COUNT_W'(pli_pkg::CAPACITY))
      else $error("entry count beyond capacity");

   // requests other than dump answer in the next cycle
   a_single_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.action != pli_pkg::ACT_DUMP |=>
         rsp_valid && rsp_payload.last_of_run)
      else $error("missing result after request");

endmodule

bind positional_list_insert_remove pli_checker u_pli_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 240;
   localparam int MAX_REPORT = 10;
   localparam int MAX_GAP    = 14;

   typedef struct packed {
      pli_pkg::action_type        act;
      logic [pli_pkg::POS_W-1:0]  pos;
      logic [pli_pkg::DATA_W-1:0] data;
      bit                         known;
      pli_pkg::rsp_type           want;
   } step_row_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   pli_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   pli_pkg::rsp_type rsp_payload;

   // shadow copy of the list
   logic [pli_pkg::ENTRY_WIDTH-1:0] shadow_list [pli_pkg::CAPACITY];
   int                              shadow_len = 0;
   pli_pkg::rsp_type                results_due [$];
   step_row_type                    steps [$];

   bit idling_on    = 1'b1;
   bit hold_request = 1'b0;
   int mismatches   = 0;
   int requests_done = 0;
   int results_seen = 0;
   int rejects_seen = 0;
   int peak_len     = 0;
   int quiet_cycles = 0;

   positional_list_insert_remove u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // updates the shadow list and queues the results one request owes
   task automatic apply_list_action(input pli_pkg::req_type r);
      pli_pkg::rsp_type res;
      int               idx;
      int               i;
      res = '0;
      res.last_of_run = 1'b1;
      case (r.action)
         pli_pkg::ACT_INSERT_FRONT, pli_pkg::ACT_INSERT_BACK, pli_pkg::ACT_INSERT_AT: begin
            idx = (r.action == pli_pkg::ACT_INSERT_FRONT) ? 0 :
                  (r.action == pli_pkg::ACT_INSERT_BACK) ? shadow_len : int'(r.position);
            if (shadow_len >= pli_pkg::CAPACITY || idx > shadow_len) begin
               res.status = pli_pkg::STATUS_INSERT_REJ;
            end else begin
               for (i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[idx] = r.entry_in[pli_pkg::ENTRY_WIDTH-1:0];
               shadow_len++;
            end
         end
         pli_pkg::ACT_REMOVE_FRONT, pli_pkg::ACT_REMOVE_BACK, pli_pkg::ACT_REMOVE_AT: begin
            idx = (r.action == pli_pkg::ACT_REMOVE_FRONT) ? 0 :
                  (r.action == pli_pkg::ACT_REMOVE_BACK) ? shadow_len - 1 : int'(r.position);
            if (shadow_len == 0 || idx >= shadow_len) begin
               res.status = pli_pkg::STATUS_REMOVE_REJ;
            end else begin
               res.entry_out = shadow_list[idx];
               shadow_len--;
               for (i = idx; i < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
            end
         end
         pli_pkg::ACT_CLEAR: begin
            shadow_len = 0;
         end
         default: begin
            // dump streams the whole list, one transaction per entry
            if (shadow_len > 0) begin
               for (i = 0; i < shadow_len; i++) begin
                  res.entry_out   = shadow_list[i];
                  res.entry_count = pli_pkg::COUNT_W'(shadow_len);
                  res.last_of_run = (i == shadow_len - 1);
                  results_due.push_back(res);
               end
               return;
            end
         end
      endcase
      res.entry_count = pli_pkg::COUNT_W'(shadow_len);
      results_due.push_back(res);
   endtask

   task automatic send_list_request(input pli_pkg::req_type r, input bit known,
                                    input pli_pkg::rsp_type want);
      int gap;
      gap = idling_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      apply_list_action(r);
      if (known) begin
         void'(results_due.pop_back());
         results_due.push_back(want);
      end
      requests_done++;
      if (shadow_len > peak_len) peak_len = shadow_len;
   endtask

   // positions mostly near the legal range, now and then anywhere in the field
   function automatic pli_pkg::req_type pick_list_request(input int insert_pct,
                                                          input bit clear_ok);
      pli_pkg::req_type r;
      int               roll;
      roll       = $urandom_range(0, 99);
      r.entry_in = $urandom;
      if (roll < insert_pct) r.action = pli_pkg::action_type'($urandom_range(0, 2));
      else if (roll < 97) r.action = pli_pkg::action_type'($urandom_range(3, 5));
      else if (roll < 98) r.action = clear_ok ? pli_pkg::ACT_CLEAR : pli_pkg::ACT_DUMP;
      else r.action = pli_pkg::ACT_DUMP;
      if ($urandom_range(0, 9) == 0) r.position = pli_pkg::POS_W'($urandom_range(0, 127));
      else r.position = pli_pkg::POS_W'($urandom_range(0, shadow_len));
      return r;
   endfunction

   task automatic add_step(input pli_pkg::action_type act, input int pos,
                           input logic [31:0] data, input bit known,
                           input logic [pli_pkg::STATUS_W-1:0] st, input int cnt);
      step_row_type s;
      s.act              = act;
      s.pos              = pli_pkg::POS_W'(pos);
      s.data             = data;
      s.known            = known;
      s.want.entry_out   = '0;
      s.want.status      = st;
      s.want.entry_count = pli_pkg::COUNT_W'(cnt);
      s.want.last_of_run = 1'b1;
      steps.push_back(s);
   endtask

   // sender goes idle and waits for every owed result
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = idling_on ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : rsp_check
      pli_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_payload.status != pli_pkg::STATUS_OK) rejects_seen++;
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
               $display("unexpected transaction: out=%h status=%0d count=%0d last=%0b",
                        rsp_payload.entry_out, rsp_payload.status,
                        rsp_payload.entry_count, rsp_payload.last_of_run);
         end else begin
            want = results_due.pop_front();
            if (rsp_payload.entry_out !== want.entry_out ||
                rsp_payload.status !== want.status ||
                rsp_payload.entry_count !== want.entry_count ||
                rsp_payload.last_of_run !== want.last_of_run) begin
               mismatches++;
               if (mismatches <= MAX_REPORT)
                  $display("mismatch: out %h/%h status %0d/%0d count %0d/%0d last %0b/%0b",
                           want.entry_out, rsp_payload.entry_out,
                           want.status, rsp_payload.status,
                           want.entry_count, rsp_payload.entry_count,
                           want.last_of_run, rsp_payload.last_of_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("[positional_list_insert_remove] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      step_row_type     s;
      pli_pkg::req_type r;
      int               n;

      // short directed walk: empty list, bounds, each action
      add_step(pli_pkg::ACT_REMOVE_FRONT, 0,   32'h0,        1, pli_pkg::STATUS_REMOVE_REJ, 0);
      add_step(pli_pkg::ACT_REMOVE_AT,    0,   32'h0,        1, pli_pkg::STATUS_REMOVE_REJ, 0);
      add_step(pli_pkg::ACT_DUMP,         0,   32'h0,        1, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_INSERT_AT,    1,   32'hDEADBEEF, 1, pli_pkg::STATUS_INSERT_REJ, 0);
      add_step(pli_pkg::ACT_INSERT_AT,    0,   32'hFFFFFFFF, 1, pli_pkg::STATUS_OK,         1);
      add_step(pli_pkg::ACT_INSERT_FRONT, 127, 32'h00000000, 1, pli_pkg::STATUS_OK,         2);
      add_step(pli_pkg::ACT_INSERT_BACK,  0,   32'hA5A5A5A5, 1, pli_pkg::STATUS_OK,         3);
      add_step(pli_pkg::ACT_INSERT_AT,    3,   32'h5A5A5A5A, 1, pli_pkg::STATUS_OK,         4);
      add_step(pli_pkg::ACT_INSERT_AT,    127, 32'h11111111, 1, pli_pkg::STATUS_INSERT_REJ, 4);
      add_step(pli_pkg::ACT_INSERT_AT,    64,  32'h22222222, 1, pli_pkg::STATUS_INSERT_REJ, 4);
      add_step(pli_pkg::ACT_INSERT_AT,    2,   32'h12345678, 0, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_DUMP,         0,   32'h0,        0, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_REMOVE_AT,    5,   32'h0,        1, pli_pkg::STATUS_REMOVE_REJ, 5);
      add_step(pli_pkg::ACT_REMOVE_AT,    127, 32'h0,        1, pli_pkg::STATUS_REMOVE_REJ, 5);
      add_step(pli_pkg::ACT_REMOVE_AT,    1,   32'h0,        0, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_REMOVE_BACK,  0,   32'h0,        0, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_REMOVE_FRONT, 0,   32'h0,        0, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_CLEAR,        0,   32'hFFFFFFFF, 1, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_DUMP,         0,   32'h0,        1, pli_pkg::STATUS_OK,         0);
      add_step(pli_pkg::ACT_REMOVE_BACK,  0,   32'h0,        1, pli_pkg::STATUS_REMOVE_REJ, 0);
      add_step(pli_pkg::ACT_INSERT_BACK,  0,   32'h80000001, 1, pli_pkg::STATUS_OK,         1);
      add_step(pli_pkg::ACT_REMOVE_AT,    0,   32'h0,        0, pli_pkg::STATUS_OK,         0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[k]) begin
         s = steps[k];
         r.action   = s.act;
         r.position = s.pos;
         r.entry_in = s.data;
         send_list_request(r, s.known, s.want);
      end

      for (n = 0; n < 100; n++) begin
         if (n % 25 == 0) idling_on = ($urandom_range(0, 3) != 0);
         send_list_request(pick_list_request(50, 1'b1), 1'b0, '0);
      end

      // sender holds back until the block has returned everything
      wait_drained();

      // fill to capacity back to back, then poke at the full list
      idling_on = 1'b0;
      n = 0;
      while (shadow_len < pli_pkg::CAPACITY && n < 200) begin
         send_list_request(pick_list_request(95, 1'b0), 1'b0, '0);
         n++;
      end
      r = '{pli_pkg::ACT_DUMP, 7'd0, 32'd0};
      send_list_request(r, 1'b0, '0);
      repeat (6) send_list_request(pick_list_request(80, 1'b0), 1'b0, '0);
      wait_drained();

      // receiver stalls for a long stretch while mostly removes keep coming
      idling_on    = 1'b1;
      hold_request = 1'b1;
      for (n = 0; n < 70; n++)
         send_list_request(pick_list_request(20, 1'b1), 1'b0, '0);

      for (n = 0; n < 110; n++) begin
         if (n % 25 == 0) idling_on = ($urandom_range(0, 3) != 0);
         send_list_request(pick_list_request(50, 1'b1), 1'b0, '0);
      end

      wait_drained();
      repeat (16) @(posedge clock);

      $display("%0d requests, %0d result transactions checked, %0d rejections",
               requests_done, results_seen, rejects_seen);
      $display("list peaked at %0d of %0d entries, %0d mismatches",
               peak_len, pli_pkg::CAPACITY, mismatches);
      if (mismatches == 0 && results_due.size() == 0) begin
         $display("[positional_list_insert_remove] OK");
      end else begin
         $display("[positional_list_insert_remove] ERROR");
      end
      $finish;
   end

endmodule
